[hdl/awm_pkg.sv]
package awm_pkg;

	// field widths fixed by the stream format
	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 18;
	localparam int FREQ_W   = 22;
	localparam int ADDR_W   = 2;

	// register map
	localparam logic [ADDR_W-1:0] REG_SAMPLE_RATE = 2'd0;

	localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 18'd44100;
	localparam logic [FREQ_W-1:0] FREQ_MAX          = 22'd3072000;

endpackage

[hdl/awm_mul.sv]
module awm_mul import awm_pkg::*; #(
	parameter int AW = 16,
	parameter int BW = 18
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [AW-1:0]              a,
	input  logic [BW-1:0]              b,
	input  logic [$clog2(AW+1)-1:0]    steps,
	output logic                       done,
	output logic [AW+BW-1:0]           prod
);

	localparam int PW = AW + BW;

	logic [AW-1:0]           a_q;
	logic [BW-1:0]           b_q;
	logic [PW-1:0]           acc_q;
	logic [$clog2(AW+1)-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;

	// shift-add, one multiplier bit per cycle, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			a_q    <= a;
			b_q    <= b;
			acc_q  <= '0;
			cnt_q  <= steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			acc_q <= {acc_q[PW-2:0], 1'b0} + (a_q[AW-1] ? PW'(b_q) : PW'(0));
			a_q   <= a_q << 1;
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[hdl/awm_div.sv]
module awm_div import awm_pkg::*; #(
	parameter int NW = 64,
	parameter int DW = 40
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [NW-1:0]            num,
	input  logic [DW-1:0]            den,
	input  logic [$clog2(NW+1)-1:0]  steps,
	output logic                     done,
	output logic [NW-1:0]            quo
);

	logic [NW-1:0]           num_q;
	logic [DW-1:0]           den_q;
	logic [DW-1:0]           rem_q;
	logic [NW-1:0]           quo_q;
	logic [$clog2(NW+1)-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DW:0]             trial;
	logic [DW:0]             diff;
	logic                    ge;

	// restoring step: shift in one numerator bit, subtract if it fits
	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
			num_q <= num_q << 1;
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hdl/awm_sqrt.sv]
module awm_sqrt import awm_pkg::*; #(
	parameter int W = 56
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     rad,
	output logic             done,
	output logic [W/2-1:0]   root
);

	localparam int HW = W / 2;

	logic [W-1:0]            rad_q;
	logic [HW+1:0]           rem_q;
	logic [HW-1:0]           root_q;
	logic [$clog2(HW+1)-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [HW+3:0]           shifted;
	logic [HW+3:0]           trial;
	logic                    ge;

	// one root bit per cycle from two radicand bits
	always_comb begin
		shifted = {rem_q, rad_q[W-1:W-2]};
		trial   = (HW+4)'({root_q, 2'b01});
		ge      = shifted >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= ($clog2(HW+1))'(HW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= ge ? (HW+2)'(shifted - trial) : (HW+2)'(shifted);
			root_q <= {root_q[HW-2:0], ge};
			rad_q  <= rad_q << 2;
			cnt_q  <= cnt_q - 1'b1;
			if (cnt_q == 1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[hdl/audio_window_level_frequency_meter.sv]
// channel   dir  tdata (lsb up)                                  tuser / tlast
// s_axis    in   sample[15:0]                                    tlast = window_last
// m_axis    out  freq_hz_x16, peak, rms, min, max, dc_mean       tuser = window_overflow
// apb       in   0x0 sample_rate[17:0]
//
// a sample holds ready low from its transaction until the block is back in idle: 16 steps of a bit-serial
// square in the shared multiplier plus start, done and return to idle.
// a rising zero crossing adds a divide of 16+CROSSING_FRAC_BITS steps for the crossing fraction.
// the window's last sample adds two full divides (NW steps each), the square root
// (half the sum-of-squares width) and, with two crossings or more at distinct positions, a multiply and a divide.
// reset clears all window state and sets sample_rate to 44100.
// a result still waiting on m_tready when the next window ends holds the block at that end.
module audio_window_level_frequency_meter import awm_pkg::*; #(
	parameter int MAX_WINDOW_FRAMES  = 1048576,
	parameter int CROSSING_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample[15:0]
	input  logic [15:0]        s_tdata,
	input  logic               s_tlast,
	input  logic               s_tvalid,
	output logic               s_tready,
	// freq_hz_x16[21:0], peak_level[37:22], rms_level[53:38], min_level[69:54],
	// max_level[85:70], dc_mean[101:86], zero pad
	output logic [103:0]       m_tdata,
	// window_overflow[0]
	output logic               m_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int F    = CROSSING_FRAC_BITS;
	localparam int FW   = $clog2(MAX_WINDOW_FRAMES + 1);
	localparam int PW   = FW + F;
	localparam int SUMW = FW + 16;
	localparam int SQW0 = FW + 31;
	localparam int SQW  = SQW0 + (SQW0 % 2);
	localparam int AW   = (FW > 16) ? FW : 16;
	localparam int FNW  = FW + 22 + F;
	localparam int NW0  = (SQW > FNW) ? SQW : FNW;
	localparam int NW   = (NW0 > SUMW) ? NW0 : SUMW;
	localparam int DW   = (PW > 17) ? PW : 17;
	localparam int NSW  = $clog2(NW + 1);
	localparam int MSW  = $clog2(AW + 1);
	localparam int HW   = SQW / 2;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_XDIV, S_END, S_MEAN, S_MSQ, S_ROOT, S_FMUL, S_FDIV, S_OUT
	} state_t;

	state_t                state_q;
	logic [RATE_W-1:0]     rate_q;

	// window state
	logic signed [15:0]    prior_q;
	logic [FW-1:0]         frame_q;
	logic signed [SUMW-1:0] sum_q;
	logic [SQW-1:0]        sq_q;
	logic signed [15:0]    min_q;
	logic signed [15:0]    max_q;
	logic [15:0]           peak_q;
	logic [PW-1:0]         first_q;
	logic [PW-1:0]         lastpos_q;
	logic [FW-1:0]         cnt_q;
	logic                  ovf_q;

	// per transaction working registers
	logic                  wlast_q;
	logic                  cross_q;
	logic [FW-1:0]         xbase_q;
	logic                  mean_neg_q;
	logic [15:0]           mean_q;
	logic [15:0]           rms_q;
	logic [FREQ_W-1:0]     freq_q;

	// shared unit operands
	logic                  mul_start_q;
	logic [AW-1:0]         mul_a_q;
	logic [RATE_W-1:0]     mul_b_q;
	logic [MSW-1:0]        mul_steps_q;
	logic                  mul_done;
	logic [AW+RATE_W-1:0]  mul_prod;
	logic                  div_start_q;
	logic [NW-1:0]         div_num_q;
	logic [DW-1:0]         div_den_q;
	logic [NSW-1:0]        div_steps_q;
	logic                  div_done;
	logic [NW-1:0]         div_quo;
	logic                  sqrt_start_q;
	logic [SQW-1:0]        sqrt_rad_q;
	logic                  sqrt_done;
	logic [HW-1:0]         sqrt_root;

	// output register
	logic                  out_valid_q;
	logic [103:0]          out_data_q;
	logic                  out_user_q;

	logic                  fire;
	logic signed [15:0]    s_in;
	logic [15:0]           mag;
	logic [15:0]           neg;
	logic [16:0]           span;
	logic [FW-1:0]         n;
	logic [SUMW-1:0]       sum_abs;
	logic [PW-1:0]         pos;
	logic [15:0]           qmean;

	awm_mul #(.AW(AW), .BW(RATE_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .a(mul_a_q), .b(mul_b_q),
		.steps(mul_steps_q), .done(mul_done), .prod(mul_prod)
	);

	awm_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .num(div_num_q), .den(div_den_q),
		.steps(div_steps_q), .done(div_done), .quo(div_quo)
	);

	awm_sqrt #(.W(SQW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start_q), .rad(sqrt_rad_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	// input side decode
	always_comb begin
		s_in    = $signed(s_tdata);
		mag     = s_in[15] ? 16'(-s_in) : 16'(s_in);
		neg     = 16'(-prior_q);
		span    = 17'({s_in[15], s_in} - {prior_q[15], prior_q});
		n       = (frame_q == '0) ? FW'(1) : frame_q;
		sum_abs = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
		pos     = (PW'(xbase_q) << F) + PW'(div_quo[F:0]);
		qmean   = div_quo[15:0];
	end

	assign s_tready = (state_q == S_IDLE);
	assign fire     = s_tvalid && s_tready;

	// sequencer, window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prior_q      <= '0;
			frame_q      <= '0;
			sum_q        <= '0;
			sq_q         <= '0;
			min_q        <= '0;
			max_q        <= '0;
			peak_q       <= '0;
			first_q      <= '0;
			lastpos_q    <= '0;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			wlast_q      <= 1'b0;
			cross_q      <= 1'b0;
			xbase_q      <= '0;
			mean_neg_q   <= 1'b0;
			mean_q       <= '0;
			rms_q        <= '0;
			freq_q       <= '0;
			mul_start_q  <= 1'b0;
			mul_a_q      <= '0;
			mul_b_q      <= '0;
			mul_steps_q  <= '0;
			div_start_q  <= 1'b0;
			div_num_q    <= '0;
			div_den_q    <= '0;
			div_steps_q  <= '0;
			sqrt_start_q <= 1'b0;
			sqrt_rad_q   <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_user_q   <= 1'b0;
		end else begin
			mul_start_q  <= 1'b0;
			div_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
			if (out_valid_q && m_tready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (fire) begin
						wlast_q <= s_tlast;
						if (frame_q >= FW'(MAX_WINDOW_FRAMES)) begin
							ovf_q   <= 1'b1;
							state_q <= s_tlast ? S_END : S_IDLE;
						end else begin
							if (frame_q == '0) begin
								min_q <= s_in;
								max_q <= s_in;
							end else begin
								if (s_in < min_q) min_q <= s_in;
								if (s_in > max_q) max_q <= s_in;
							end
							if (mag > peak_q) peak_q <= mag;
							sum_q   <= sum_q + SUMW'(s_in);
							prior_q <= s_in;
							frame_q <= frame_q + 1'b1;
							cross_q <= (frame_q != '0) && prior_q[15] && !s_in[15];
							xbase_q <= frame_q - 1'b1;
							// crossing fraction operands, msb aligned
							div_num_q   <= NW'(neg) << (NW - 16);
							div_den_q   <= DW'(span);
							div_steps_q <= NSW'(16 + F);
							// square of the magnitude
							mul_a_q     <= AW'(mag) << (AW - 16);
							mul_b_q     <= RATE_W'(mag);
							mul_steps_q <= MSW'(16);
							mul_start_q <= 1'b1;
							state_q     <= S_SQ;
						end
					end
				end
				S_SQ: begin
					if (mul_done) begin
						sq_q <= sq_q + SQW'(mul_prod[30:0]);
						if (cross_q) begin
							div_start_q <= 1'b1;
							state_q     <= S_XDIV;
						end else begin
							state_q <= wlast_q ? S_END : S_IDLE;
						end
					end
				end
				S_XDIV: begin
					if (div_done) begin
						if (cnt_q == '0) first_q <= pos;
						lastpos_q <= pos;
						cnt_q     <= cnt_q + 1'b1;
						state_q   <= wlast_q ? S_END : S_IDLE;
					end
				end
				S_END: begin
					// signed dc mean first, divided as a magnitude
					mean_neg_q  <= sum_q[SUMW-1];
					div_num_q   <= NW'(sum_abs);
					div_den_q   <= DW'(n);
					div_steps_q <= NSW'(NW);
					div_start_q <= 1'b1;
					state_q     <= S_MEAN;
				end
				S_MEAN: begin
					if (div_done) begin
						mean_q      <= mean_neg_q ? 16'(-qmean) : qmean;
						div_num_q   <= NW'(sq_q);
						div_start_q <= 1'b1;
						state_q     <= S_MSQ;
					end
				end
				S_MSQ: begin
					if (div_done) begin
						sqrt_rad_q   <= div_quo[SQW-1:0];
						sqrt_start_q <= 1'b1;
						state_q      <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (sqrt_done) begin
						rms_q <= sqrt_root[15:0];
						if (cnt_q >= FW'(2) && lastpos_q > first_q) begin
							mul_a_q     <= AW'(cnt_q - 1'b1);
							mul_b_q     <= rate_q;
							mul_steps_q <= MSW'(AW);
							mul_start_q <= 1'b1;
							state_q     <= S_FMUL;
						end else begin
							freq_q  <= '0;
							state_q <= S_OUT;
						end
					end
				end
				S_FMUL: begin
					if (mul_done) begin
						div_num_q   <= NW'({mul_prod[FW+17:0], (4 + F)'(0)});
						div_den_q   <= DW'(lastpos_q - first_q);
						div_steps_q <= NSW'(NW);
						div_start_q <= 1'b1;
						state_q     <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (div_done) begin
						freq_q  <= (div_quo > NW'(FREQ_MAX)) ? FREQ_MAX : div_quo[FREQ_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {2'b00, mean_q, max_q, min_q, rms_q, peak_q, freq_q};
						out_user_q  <= ovf_q;
						// clear window
						prior_q   <= '0;
						frame_q   <= '0;
						sum_q     <= '0;
						sq_q      <= '0;
						min_q     <= '0;
						max_q     <= '0;
						peak_q    <= '0;
						first_q   <= '0;
						lastpos_q <= '0;
						cnt_q     <= '0;
						ovf_q     <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= SAMPLE_RATE_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_SAMPLE_RATE) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SAMPLE_RATE) ? 32'(rate_q) : 32'd0;

endmodule
